FILE: rtl/core/xtea_pkg.sv
// Package for the XTEA block cipher: payload types, register map, constants and round helpers.
package xtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MAX_ROUNDS = 64;
  // Two half-round stages per round
  localparam int unsigned NUM_STAGES = 2 * MAX_ROUNDS;

  localparam logic [WORD_W-1:0]  DELTA        = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0]  KEY0_RESET   = 32'h0000_3154;
  localparam logic [WORD_W-1:0]  KEY1_RESET   = 32'h0000_5346;
  localparam logic [WORD_W-1:0]  KEY2_RESET   = 32'h0000_2157;
  localparam logic [WORD_W-1:0]  KEY3_RESET   = 32'h0000_4314;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd32;
  localparam logic [ROUND_W-1:0] ROUNDS_MAX   = ROUND_W'(MAX_ROUNDS);

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // Input beat
  typedef struct packed {
    op_e               opcode;
    logic [WORD_W-1:0] block_first;
    logic [WORD_W-1:0] block_second;
  } cmd_t;

  // Output beat
  typedef struct packed {
    logic [WORD_W-1:0] result_first;
    logic [WORD_W-1:0] result_second;
  } rsp_t;

  // Working state carried down the pipeline
  typedef struct packed {
    op_e               opcode;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] sum;
  } stage_t;

  // Per-stage control from the top level
  typedef struct packed {
    logic en;
    logic active;
    logic second_half;
  } stage_ctl_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

FILE: rtl/core/xtea_block_cipher.sv
// Top level of the pipelined XTEA block cipher with its configuration registers.
// One 64-bit block is taken per cycle while the pipeline is not held for a waiting result,
// and passes through an entry register followed by one register stage
// per half-round, all rounds always traversed, stages beyond the round count passing
// data through. Results stay in order; when a result waits at the output, the whole
// pipeline holds, so in_ready_o follows out_ready_i whenever the last stage is full.
// The key words and round count must be written only while the pipeline is empty;
// a round count above MAX_ROUNDS is treated as MAX_ROUNDS and zero passes data through.
module xtea_block_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  xtea_pkg::cmd_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output xtea_pkg::rsp_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]     cfg_data_i
);
  import xtea_pkg::*;

  key_t               key_q;
  logic [ROUND_W-1:0] round_q;
  logic [ROUND_W-1:0] n_eff;
  logic [WORD_W-1:0]  sum_init;
  logic               en;

  logic               valid_v [NUM_STAGES+1];
  stage_t             data_v  [NUM_STAGES+1];
  logic               entry_valid_q;
  stage_t             entry_data_q, entry_data_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KEY0_RESET;
      key_q[1] <= KEY1_RESET;
      key_q[2] <= KEY2_RESET;
      key_q[3] <= KEY3_RESET;
      round_q  <= ROUNDS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0:   key_q[0] <= cfg_data_i;
        CFG_KEY1:   key_q[1] <= cfg_data_i;
        CFG_KEY2:   key_q[2] <= cfg_data_i;
        CFG_KEY3:   key_q[3] <= cfg_data_i;
        CFG_ROUNDS: round_q  <= cfg_data_i[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated round count and decrypt start sum
  assign n_eff    = (round_q > ROUNDS_MAX) ? ROUNDS_MAX : round_q;
  assign sum_init = DELTA * WORD_W'(n_eff);

  // Whole pipeline advances unless a result is held at the output
  assign en         = !valid_v[NUM_STAGES] || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: load block and start sum
  always_comb begin
    entry_data_d.opcode = in_data_i.opcode;
    entry_data_d.a      = in_data_i.block_first;
    entry_data_d.b      = in_data_i.block_second;
    entry_data_d.sum    = (in_data_i.opcode == OP_DECRYPT) ? sum_init : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (en) begin
      entry_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      entry_data_q <= entry_data_d;
    end
  end

  assign valid_v[0] = entry_valid_q;
  assign data_v[0]  = entry_data_q;

  // Half-round stages
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    stage_ctl_t ctl;
    assign ctl.en          = en;
    assign ctl.active      = (ROUND_W'(g / 2) < n_eff);
    assign ctl.second_half = 1'(g % 2);

    xtea_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .key_i   (key_q),
      .valid_i (valid_v[g]),
      .data_i  (data_v[g]),
      .valid_o (valid_v[g+1]),
      .data_o  (data_v[g+1])
    );
  end

  // Output beat
  assign out_valid_o              = valid_v[NUM_STAGES];
  assign out_data_o.result_first  = data_v[NUM_STAGES].a;
  assign out_data_o.result_second = data_v[NUM_STAGES].b;

`ifndef NO_ASSERTIONS
  // Entry valid follows the input handshake when the pipeline moves
  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> entry_valid_q == $past(in_valid_i))
    else $error("entry valid did not follow accepted input");

  // A stall freezes the middle of the pipeline
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_v[MAX_ROUNDS]) && $stable(data_v[MAX_ROUNDS]))
    else $error("pipeline stage moved during a stall");

  // Last stage valid takes the valid of the stage before it on each advance
  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> valid_v[NUM_STAGES] == $past(valid_v[NUM_STAGES-1]))
    else $error("valid bit lost or duplicated at the last stage");

  // Effective round count never exceeds MAX_ROUNDS and equals the written count below it
  a_rounds_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_eff <= ROUNDS_MAX) && ((round_q > ROUNDS_MAX) || (n_eff == round_q)))
    else $error("round count saturation wrong");
`endif

endmodule

FILE: rtl/core/xtea_stage.sv
// One XTEA half-round pipeline stage with its valid bit.
module xtea_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xtea_pkg::stage_ctl_t ctl_i,
  input  xtea_pkg::key_t      key_i,
  input  logic                valid_i,
  input  xtea_pkg::stage_t    data_i,
  output logic                valid_o,
  output xtea_pkg::stage_t    data_o
);
  import xtea_pkg::*;

  logic              valid_q;
  stage_t            data_q, data_d;
  logic              update_a;
  logic              decrypt;
  logic [1:0]        key_sel;
  logic [WORD_W-1:0] mix_src;
  logic [WORD_W-1:0] target;
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] target_new;

  // Which word this half updates: first half of encrypt and second half of decrypt touch a
  always_comb begin
    decrypt  = (data_i.opcode == OP_DECRYPT);
    update_a = (ctl_i.second_half == decrypt);
    mix_src  = update_a ? data_i.b : data_i.a;
    target   = update_a ? data_i.a : data_i.b;
    key_sel  = update_a ? data_i.sum[1:0] : data_i.sum[12:11];
    f_val    = mix(mix_src) ^ (data_i.sum + key_i[key_sel]);
    target_new = decrypt ? (target - f_val) : (target + f_val);
  end

  // Next working state; stages past the round count pass through
  always_comb begin
    data_d = data_i;
    if (ctl_i.active) begin
      if (update_a) begin
        data_d.a = target_new;
      end else begin
        data_d.b = target_new;
      end
      if (!ctl_i.second_half) begin
        data_d.sum = decrypt ? (data_i.sum - DELTA) : (data_i.sum + DELTA);
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sim/xtea_block_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the XTEA block cipher: directed and random blocks under stalls.
module xtea_block_cipher_tb;
  import xtea_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  cmd_t                 in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  rsp_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [WORD_W-1:0]    cfg_data_i  = '0;

  // Shadow copy of the key and round count registers
  logic [WORD_W-1:0]  key_shadow [KEY_WORDS] = '{KEY0_RESET, KEY1_RESET, KEY2_RESET, KEY3_RESET};
  logic [ROUND_W-1:0] rounds_shadow = ROUNDS_RESET;

  cmd_t block_cmds_q  [$];  // blocks waiting to be sent
  rsp_t want_blocks_q [$];  // transformed blocks still owed by the pipeline

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int blocks_sent    = 0;
  int blocks_seen    = 0;
  int err_count      = 0;

  xtea_block_cipher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Encipher or decipher one block under the shadow key and round count
  function automatic rsp_t cipher_block(input cmd_t c);
    logic [WORD_W-1:0] a, b, sum, f;
    int unsigned       n;
    a = c.block_first;
    b = c.block_second;
    n = (rounds_shadow > ROUNDS_MAX) ? MAX_ROUNDS : rounds_shadow;
    if (c.opcode == OP_ENCRYPT) begin
      sum = '0;
      for (int i = 0; i < n; i++) begin
        f = ((b << 4) ^ (b >> 5)) + b;
        a += f ^ (sum + key_shadow[sum[1:0]]);
        sum += DELTA;
        f = ((a << 4) ^ (a >> 5)) + a;
        b += f ^ (sum + key_shadow[sum[12:11]]);
      end
    end else begin
      sum = DELTA * n;
      for (int i = 0; i < n; i++) begin
        f = ((a << 4) ^ (a >> 5)) + a;
        b -= f ^ (sum + key_shadow[sum[12:11]]);
        sum -= DELTA;
        f = ((b << 4) ^ (b >> 5)) + b;
        a -= f ^ (sum + key_shadow[sum[1:0]]);
      end
    end
    return '{result_first: a, result_second: b};
  endfunction

  // Word with a bias towards all-zero, all-one and single-bit patterns
  function automatic logic [WORD_W-1:0] rand_word();
    unique case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // Queue one block; a round trip adds the inverse operation on its predicted output
  function automatic void queue_block(input cmd_t c, input bit round_trip);
    cmd_t back;
    rsp_t r;
    block_cmds_q.push_back(c);
    if (round_trip) begin
      r                 = cipher_block(c);
      back.opcode       = (c.opcode == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
      back.block_first  = r.result_first;
      back.block_second = r.result_second;
      block_cmds_q.push_back(back);
    end
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  // One register write per clock; the shadow follows the block's decode
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx <= CFG_KEY3) begin
      key_shadow[idx[1:0]] = val;
    end else if (idx == CFG_ROUNDS) begin
      rounds_shadow = val[ROUND_W-1:0];
    end
  endtask

  // Hold until every queued block has gone in and come back out
  task automatic wait_idle();
    while (block_cmds_q.size() != 0 || in_valid_i || want_blocks_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Input driver: valid is held with stable data until the beat is taken
  always @(posedge clk_i or negedge rst_ni) begin : in_driver
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        want_blocks_q.push_back(cipher_block(in_data_i));
        void'(block_cmds_q.pop_front());
        blocks_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && block_cmds_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= block_cmds_q[0];
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
    end
  end

  // Output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor: each beat against the oldest owed block
  always @(posedge clk_i) begin : out_monitor
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      blocks_seen++;
      if (want_blocks_q.size() == 0) begin
        flag_error($sformatf("result %h with nothing outstanding", out_data_o));
      end else begin
        want = want_blocks_q.pop_front();
        if (out_data_o.result_first !== want.result_first)
          flag_error($sformatf("result_first %h, want %h",
                               out_data_o.result_first, want.result_first));
        if (out_data_o.result_second !== want.result_second)
          flag_error($sformatf("result_second %h, want %h",
                               out_data_o.result_second, want.result_second));
      end
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0]  kv;
    logic [ROUND_W-1:0] rc;
    int                 key_sel;
    int                 n_fill;
    cmd_t               c;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed blocks under the reset key and 32 rounds, no idling
    queue_block('{OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    queue_block('{OP_DECRYPT, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    queue_block('{OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
    queue_block('{OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
    queue_block('{OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0);
    queue_block('{OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0);
    queue_block('{OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001}, 1'b0);
    queue_block('{OP_DECRYPT, 32'h0000_0001, 32'h8000_0000}, 1'b0);
    queue_block('{OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1);
    queue_block('{OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1);
    queue_block('{OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF}, 1'b1);
    wait_idle();

    // Random phases, each with its key, round count and idling pattern set per phase
    for (int p = 0; p < 9; p++) begin
      unique case (p)
        0:       begin key_sel = 0; rc = 7'd32; end
        1:       begin key_sel = 1; rc = 7'd1; end
        2:       begin key_sel = 2; rc = ROUNDS_MAX; end
        3:       begin key_sel = 0; rc = 7'd0; end             // pass-through
        4:       begin key_sel = 0; rc = ROUNDS_MAX + 7'd1; end // saturates
        5:       begin key_sel = 0; rc = 7'd127; end
        6:       begin key_sel = 0; rc = ROUND_W'($urandom_range(1, MAX_ROUNDS)); end
        7:       begin key_sel = 0; rc = ROUND_W'($urandom_range(0, 127)); end
        default: begin key_sel = 0; rc = ROUNDS_RESET; end
      endcase
      for (int k = 0; k < KEY_WORDS; k++) begin
        kv = (key_sel == 1) ? '0 : (key_sel == 2) ? '1 : $urandom();
        write_reg(CFG_IDX_W'(k), kv);
      end
      // Upper data bits are noise above the round field
      kv = $urandom();
      kv[ROUND_W-1:0] = rc;
      write_reg(CFG_ROUNDS, kv);
      // Unmapped indexes must leave every register alone
      if (p == 0 || p == 7) begin
        for (int j = CFG_ROUNDS + 1; j < (1 << CFG_IDX_W); j++)
          write_reg(CFG_IDX_W'(j), $urandom());
      end
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      unique case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase

      n_fill = 0;
      while (n_fill < 48) begin
        c.opcode       = op_e'($urandom_range(1));
        c.block_first  = rand_word();
        c.block_second = rand_word();
        queue_block(c, $urandom_range(3) == 0);
        n_fill = block_cmds_q.size();
      end
      // Sender holds off until the pipeline has fully drained
      wait_idle();
    end

    repeat (2 * NUM_STAGES + 16) @(posedge clk_i);
    if (want_blocks_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", want_blocks_q.size()));

    $display("Covered %0d blocks both ways, round counts 0 to 127, zero and all-one keys,",
             blocks_sent);
    $display("stalls on either side; %0d results checked, %0d errors.", blocks_seen, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d blocks sent, %0d results seen", blocks_sent, blocks_seen);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
